/* rtl/bbf_pkg.sv */
// Shared types and constants for the box blur filter.
package bbf_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_RADIUS       = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Field widths of the pixel and configuration data.
  localparam int PIX_W = 8;
  localparam int POS_W = 12;
  localparam int CFG_W = 13;
  localparam int RAD_W = 2;

  // Accumulator width: a 7 x 7 window of 8-bit pixels fits in 14 bits.
  localparam int ACC_W = 16;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_WAIT = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

endpackage

/* rtl/box_blur_filter_top.sv */
// Top level of the streaming box blur filter.
//
// Pixels enter in raster order, one transfer each. Every pixel is written into a line
// memory of 2*MAX_RADIUS+1 rows. A pixel that completes a full window (row and column
// both at least 2r) then starts a window pass: the (2r+1)^2 window entries are read
// one per cycle through the single read port of the line memory, summed, and divided
// by (2r+1)^2 in an 8-step restoring divider. Such a pixel holds in_ready low until
// its result is loaded into the result register; a border pixel is only written.
// The result register lets the next pixel be taken while a result waits.
module box_blur_filter_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Pixel input channel.
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [bbf_pkg::PIX_W-1:0] in_pixel_in,
  input  logic                     in_frame_start,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [bbf_pkg::PIX_W-1:0] out_pixel_out,
  output logic [bbf_pkg::POS_W-1:0] out_row,
  output logic [bbf_pkg::POS_W-1:0] out_col,
  output logic                     out_frame_last,
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [bbf_pkg::CFG_W-1:0] cfg_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int SLOTS = 2 * MAX_RADIUS + 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int AW    = SW + XW;
  localparam int DEPTH = SLOTS * (2 ** XW);

  localparam int PW = bbf_pkg::PIX_W;
  localparam int AC = bbf_pkg::ACC_W;

  // Advance a row slot, wrapping at the number of stored rows.
  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    logic [SW-1:0] n;
    if (32'(s) == SLOTS - 1) begin
      n = '0;
    end else begin
      n = SW'(32'(s) + 1);
    end
    return n;
  endfunction

  // Configuration registers.
  logic [bbf_pkg::RAD_W-1:0] cfg_radius_r;
  logic [bbf_pkg::CFG_W-1:0] cfg_width_r;
  logic [bbf_pkg::CFG_W-1:0] cfg_height_r;

  // Position and sequencing state.
  bbf_pkg::state_t state_r, state_nxt;
  logic [XW-1:0]   col_r, col_nxt;
  logic [YW-1:0]   row_r, row_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic [XW-1:0]   x0_r;
  logic [XW-1:0]   rd_col_r;
  logic [SW-1:0]   rd_slot_r;
  logic [2:0]      k_r;
  logic [2:0]      l_r;
  logic            rd_pend_r;
  logic [AC-1:0]   acc_r;
  logic [PW-1:0]   q_r;
  logic [2:0]      bit_r;
  logic [bbf_pkg::POS_W-1:0] res_row_r;
  logic [bbf_pkg::POS_W-1:0] res_col_r;
  logic            res_last_r;

  // Result register.
  logic            out_valid_r;
  logic [PW-1:0]   out_pixel_r;
  logic [bbf_pkg::POS_W-1:0] out_row_r;
  logic [bbf_pkg::POS_W-1:0] out_col_r;
  logic            out_last_r;

  // Effective register values after clamping.
  logic [bbf_pkg::RAD_W-1:0] r_eff;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [2:0]      two_r;
  logic [2:0]      side;
  logic [5:0]      divisor;

  always_comb begin
    if (32'(cfg_radius_r) > MAX_RADIUS) begin
      r_eff = bbf_pkg::RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = cfg_radius_r;
    end
    if (cfg_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height_r);
    end
  end

  assign two_r   = {r_eff, 1'b0};
  assign side    = two_r + 3'd1;
  assign divisor = 6'(side) * 6'(side);

  // Handshakes.
  logic in_fire;
  logic out_fire;
  logic emit_load;

  assign in_ready  = (state_r == bbf_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign emit_load = (state_r == bbf_pkg::ST_EMIT) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  // Position of the incoming pixel, including frame start and wrap rules.
  logic [XW-1:0] cur_x;
  logic [YW-1:0] cur_y;
  logic [SW-1:0] cur_s;
  logic [SW-1:0] start_slot;
  logic          interior;

  always_comb begin
    logic [31:0] y_tmp;
    logic [SW-1:0] s_tmp;
    logic [XW-1:0] x_tmp;
    x_tmp = in_frame_start ? '0 : col_r;
    y_tmp = in_frame_start ? 32'd0 : 32'(row_r);
    s_tmp = in_frame_start ? '0 : slot_r;
    if (32'(x_tmp) >= 32'(w_eff)) begin
      x_tmp = '0;
      y_tmp = y_tmp + 32'd1;
      s_tmp = slot_inc(s_tmp);
    end
    if (y_tmp >= 32'(h_eff)) begin
      y_tmp = 32'd0;
      s_tmp = '0;
    end
    cur_x = x_tmp;
    cur_y = YW'(y_tmp);
    cur_s = s_tmp;
  end

  assign interior = (32'(cur_y) >= 32'(two_r)) && (32'(cur_x) >= 32'(two_r));

  // Row slot of the top window row, modulo the stored row count.
  always_comb begin
    if (32'(cur_s) >= 32'(two_r)) begin
      start_slot = SW'(32'(cur_s) - 32'(two_r));
    end else begin
      start_slot = SW'(32'(cur_s) + SLOTS - 32'(two_r));
    end
  end

  // Position of the pixel after this one.
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (in_fire) begin
      if (32'(cur_x) + 32'd1 >= 32'(w_eff)) begin
        col_nxt = '0;
        if (32'(cur_y) + 32'd1 >= 32'(h_eff)) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = YW'(32'(cur_y) + 32'd1);
          slot_nxt = slot_inc(cur_s);
        end
      end else begin
        col_nxt = XW'(32'(cur_x) + 32'd1);
        row_nxt = cur_y;
        slot_nxt = cur_s;
      end
    end
  end

  // Sequencer next state.
  logic read_last;
  assign read_last = (l_r == side - 3'd1) && (k_r == side - 3'd1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bbf_pkg::ST_IDLE: begin
        if (in_fire && interior) begin
          state_nxt = bbf_pkg::ST_READ;
        end
      end
      bbf_pkg::ST_READ: begin
        if (read_last) begin
          state_nxt = bbf_pkg::ST_WAIT;
        end
      end
      bbf_pkg::ST_WAIT: begin
        state_nxt = bbf_pkg::ST_DIV;
      end
      bbf_pkg::ST_DIV: begin
        if (bit_r == 3'd0) begin
          state_nxt = bbf_pkg::ST_EMIT;
        end
      end
      bbf_pkg::ST_EMIT: begin
        if (emit_load) begin
          state_nxt = bbf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bbf_pkg::ST_IDLE;
      end
    endcase
  end

  // Line memory.
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [PW-1:0] rdata;

  assign waddr = {cur_s, cur_x};
  assign raddr = {rd_slot_r, rd_col_r};

  bbf_ram #(
    .WIDTH(PW),
    .DEPTH(DEPTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (in_fire),
    .waddr(waddr),
    .wdata(in_pixel_in),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Divider trial subtraction.
  logic [AC-1:0] div_shift;
  assign div_shift = AC'(divisor) << bit_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bbf_pkg::ST_IDLE;
      col_r        <= '0;
      row_r        <= '0;
      slot_r       <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      cfg_radius_r <= bbf_pkg::RAD_W'(1);
      cfg_width_r  <= bbf_pkg::CFG_W'(2560);
      cfg_height_r <= bbf_pkg::CFG_W'(2560);
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      slot_r    <= slot_nxt;
      rd_pend_r <= (state_r == bbf_pkg::ST_READ);
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bbf_pkg::REG_RADIUS:       cfg_radius_r <= cfg_data[bbf_pkg::RAD_W-1:0];
          bbf_pkg::REG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data;
          bbf_pkg::REG_IMAGE_HEIGHT: cfg_height_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Window walk, accumulation and division datapath.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x0_r       <= XW'(32'(cur_x) - 32'(two_r));
      rd_col_r   <= XW'(32'(cur_x) - 32'(two_r));
      rd_slot_r  <= start_slot;
      k_r        <= '0;
      l_r        <= '0;
      acc_r      <= '0;
      q_r        <= '0;
      bit_r      <= 3'd7;
      res_row_r  <= bbf_pkg::POS_W'(32'(cur_y) - 32'(r_eff));
      res_col_r  <= bbf_pkg::POS_W'(32'(cur_x) - 32'(r_eff));
      res_last_r <= (32'(cur_y) == 32'(h_eff) - 32'd1) &&
                    (32'(cur_x) == 32'(w_eff) - 32'd1);
    end else begin
      // Step through the window, one entry per cycle.
      if (state_r == bbf_pkg::ST_READ) begin
        if (l_r == side - 3'd1) begin
          l_r       <= '0;
          k_r       <= k_r + 3'd1;
          rd_col_r  <= x0_r;
          rd_slot_r <= slot_inc(rd_slot_r);
        end else begin
          l_r      <= l_r + 3'd1;
          rd_col_r <= rd_col_r + XW'(1);
        end
      end
      // Sum the read data, then divide it down one quotient bit per cycle.
      if (rd_pend_r) begin
        acc_r <= acc_r + AC'(rdata);
      end else if (state_r == bbf_pkg::ST_DIV) begin
        if (acc_r >= div_shift) begin
          acc_r      <= acc_r - div_shift;
          q_r[bit_r] <= 1'b1;
        end
        bit_r <= bit_r - 3'd1;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_pixel_r <= q_r;
      out_row_r   <= res_row_r;
      out_col_r   <= res_col_r;
      out_last_r  <= res_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pixel_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_last = out_last_r;

endmodule

/* rtl/bbf_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module bbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
